### rtl/core/hsd_pkg.sv
// Shared constants, sideband type and elaboration-time helpers for the
// haversine slant distance pipeline. Depends on nothing else.
package hsd_pkg;

	// Field widths of the channels and the radius register.
	localparam int LAT_W    = 24;
	localparam int LON_W    = 25;
	localparam int ALT_W    = 16;
	localparam int RADIUS_W = 33;
	localparam int DIST_W   = 31;
	localparam int HCM_W    = 24;

	// Default values of the top-level parameters.
	localparam int ANGLE_FRACTION_BITS = 16;
	localparam int CORDIC_STAGES       = 32;

	// Q30 datapath width, wide enough for pi and the CORDIC growth.
	localparam int Q_W = 34;
	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

	// Square-root chains: operand widths; one cell per result bit.
	localparam int HV_NW = 62;
	localparam int FR_NW = 64;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 33'd6372797561;
	localparam logic [DIST_W-1:0]   DIST_MAX     = 31'h7FFFFFFF;

	// Coordinate limits, all strict.
	localparam int LAT_DEG = 90;
	localparam int LON_DEG = 180;
	localparam logic signed [ALT_W:0] ALT_MAX = 17'sd8848;
	localparam logic signed [ALT_W:0] ALT_MIN = -17'sd423;

	// Reciprocal of ten in Q40, rounded up; exact floor for values below 2^38.
	localparam logic [36:0] DIV10_M = 37'((64'd1 << 40) / 10 + 1);

	// Per-word data that rides beside the arithmetic.
	typedef struct packed {
		logic             ok;
		logic [HCM_W-1:0] h_cm;
	} sb_t;

	// Restoring long division, used only for constants.
	function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] rem;
		logic [63:0] q;
		rem = '0;
		q   = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], a[i]};
			if (rem >= {1'b0, b}) begin
				rem  = rem - {1'b0, b};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Integer square root, floor, used only for constants.
	function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
		logic [63:0] n;
		logic [63:0] r;
		logic [63:0] b;
		n = n_in;
		r = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Arctangent of 1/n in Q62 by its alternating series.
	function automatic logic [63:0] atan_recip(input logic [63:0] n);
		logic [63:0] term;
		logic [63:0] nn;
		logic [63:0] sum;
		logic [63:0] t;
		logic [63:0] k;
		term = udiv64(64'd1 << 62, n);
		nn   = n * n;
		sum  = '0;
		k    = '0;
		while (term != 64'd0) begin
			t = udiv64(term, 2 * k + 1);
			if (k[0]) begin
				sum = sum - t;
			end else begin
				sum = sum + t;
			end
			term = udiv64(term, nn);
			k    = k + 1;
		end
		return sum;
	endfunction

	// Quarter pi in Q62.
	function automatic logic [63:0] quarter_pi_q62();
		return 64'd4 * atan_recip(64'd5) - atan_recip(64'd239);
	endfunction

	localparam logic [63:0] QPI_Q62 = quarter_pi_q62();
	localparam logic signed [Q_W-1:0] PI_Q30 =
		Q_W'((QPI_Q62 + (64'd1 << 29)) >> 30);
	localparam logic signed [Q_W-1:0] HALF_PI_Q30 =
		Q_W'((QPI_Q62 + (64'd1 << 30)) >> 31);
	localparam logic [34:0] DEG2RAD_Q40 =
		35'((udiv64(QPI_Q62, 64'd45) + (64'd1 << 21)) >> 22);

	// CORDIC step angle atan(2^-i) in Q30, rounded to nearest. At step 31
	// the angle is just under half an LSB but is still taken as one.
	function automatic logic signed [Q_W-1:0] atan_q30(input int i);
		logic signed [Q_W-1:0] v;
		unique case (i)
			0: v = 34'sd843314857;
			1: v = 34'sd497837829;
			2: v = 34'sd263043837;
			3: v = 34'sd133525159;
			4: v = 34'sd67021687;
			5: v = 34'sd33543516;
			6: v = 34'sd16775851;
			7: v = 34'sd8388437;
			8: v = 34'sd4194283;
			9: v = 34'sd2097149;
			default: v = (i <= 30) ? (Q_W'(1) << (30 - i)) :
				((i == 31) ? Q_W'(1) : '0);
		endcase
		return v;
	endfunction

	// Start value for rotation chains: the inverse CORDIC gain in Q30.
	function automatic logic [63:0] cordic_inv_gain(input int stages);
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic signed [63:0] z;
		logic signed [63:0] dx;
		logic signed [63:0] dy;
		logic [63:0] ax;
		logic [63:0] ay;
		logic [63:0] m;
		x = 64'sd1 << 30;
		y = '0;
		z = '0;
		for (int i = 0; i < stages; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - 64'(atan_q30(i));
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + 64'(atan_q30(i));
			end
		end
		ax = (x < 0) ? 64'(-x) : 64'(x);
		ay = (y < 0) ? 64'(-y) : 64'(y);
		m  = isqrt64(ax * ax + ay * ay);
		if (m == 64'd0) begin
			m = 64'd1;
		end
		return udiv64((64'd1 << 60) + (m >> 1), m);
	endfunction

endpackage

### rtl/core/hsd_if.sv
// Channel interfaces for the point pair input and the distance result.
// Depends on hsd_pkg for the field widths.
interface hsd_pair_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [hsd_pkg::LAT_W-1:0]      first_latitude;
	logic signed [hsd_pkg::LON_W-1:0]      first_longitude;
	logic signed [hsd_pkg::ALT_W-1:0]      first_altitude;
	logic signed [hsd_pkg::LAT_W-1:0]      second_latitude;
	logic signed [hsd_pkg::LON_W-1:0]      second_longitude;
	logic signed [hsd_pkg::ALT_W-1:0]      second_altitude;

	modport source(output valid, output first_latitude, output first_longitude,
		output first_altitude, output second_latitude, output second_longitude,
		output second_altitude, input ready);
	modport sink(input valid, input first_latitude, input first_longitude,
		input first_altitude, input second_latitude, input second_longitude,
		input second_altitude, output ready);
endinterface

interface hsd_dist_if;
	logic                          valid;
	logic                          ready;
	logic [hsd_pkg::DIST_W-1:0]    distance_cm;
	logic                          coords_valid;

	modport source(output valid, output distance_cm, output coords_valid, input ready);
	modport sink(input valid, input distance_cm, input coords_valid, output ready);
endinterface

### rtl/core/haversine_slant_distance.sv
// Top level of the haversine slant distance pipeline.
// Depends on hsd_pkg, hsd_if, hsd_cordic_cell and hsd_isqrt_cell.

// Accepts one point pair per clock unless a result word waits untaken, and
// returns its slant distance in centimetres, one word per pair, in order.
// It is built from four parallel rotation chains and one vectoring chain of
// CORDIC_STAGES cells, two parallel 31-cell square-root chains, a 32-cell
// one, and the multiply stages around them. When the result word is not
// taken the whole pipeline holds. Pairs with any coordinate outside its
// limits return distance 0 with coords_valid low. The earth radius register
// is to be written by the user through cfg_wen and cfg_wdata while no pair is
// in flight, unchecked by the block; there is no clearing pass after reset.
module haversine_slant_distance #(
	parameter int ANGLE_FRACTION_BITS = hsd_pkg::ANGLE_FRACTION_BITS,
	parameter int CORDIC_STAGES       = hsd_pkg::CORDIC_STAGES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [hsd_pkg::RADIUS_W-1:0]   cfg_wdata,
	hsd_pair_if.sink                       pair_in,
	hsd_dist_if.source                     dist_out
);

	localparam int QW  = hsd_pkg::Q_W;
	localparam int CS  = CORDIC_STAGES;
	localparam int HVC = hsd_pkg::HV_NW / 2;
	localparam int FRC = hsd_pkg::FR_NW / 2;

	// Pipeline positions of the stages that read the sideband.
	localparam int IDX_S13 = 8 + HVC + 2 * CS + 4;
	localparam int L       = IDX_S13 + 2 + FRC + 1;

	localparam logic signed [QW-1:0] CORDIC_K =
		QW'(hsd_pkg::cordic_inv_gain(CORDIC_STAGES));
	localparam logic signed [QW-1:0] LAT_LIM =
		QW'(64'(hsd_pkg::LAT_DEG) << ANGLE_FRACTION_BITS);
	localparam logic signed [QW-1:0] LON_LIM =
		QW'(64'(hsd_pkg::LON_DEG) << ANGLE_FRACTION_BITS);

	// Degree to radian scaling: shift for plain angles and for half angles.
	localparam int SH0 = ANGLE_FRACTION_BITS + 10;
	localparam int SH1 = ANGLE_FRACTION_BITS + 11;
	localparam logic [61:0] RND0 = 62'(1) << (SH0 - 1);
	localparam logic [61:0] RND1 = 62'(1) << (SH1 - 1);
	localparam logic [16:0] D2R_HI = hsd_pkg::DEG2RAD_Q40[34:18];
	localparam logic [17:0] D2R_LO = hsd_pkg::DEG2RAD_Q40[17:0];
	localparam logic [16:0] M_HI   = hsd_pkg::DIV10_M[36:20];
	localparam logic [19:0] M_LO   = hsd_pkg::DIV10_M[19:0];

	logic                          adv;
	logic [L-1:0]                  vld_q;
	hsd_pkg::sb_t                  sb_q [L];
	hsd_pkg::sb_t                  sb_in;
	logic [hsd_pkg::RADIUS_W-1:0]  radius_q;

	// Radius register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= hsd_pkg::RADIUS_RESET;
		end else if (cfg_wen) begin
			radius_q <= cfg_wdata;
		end
	end

	// The pipeline moves whenever the result register is free or taken.
	assign adv            = !vld_q[L-1] || dist_out.ready;
	assign pair_in.ready  = adv;
	assign dist_out.valid = vld_q[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[L-2:0], pair_in.valid};
		end
	end

	// Range flag and altitude difference travel beside the arithmetic.
	always_ff @(posedge clk) begin
		if (adv) begin
			sb_q[0] <= sb_in;
			for (int k = 1; k < L; k++) begin
				sb_q[k] <= sb_q[k-1];
			end
		end
	end

	// Height leg in centimetres from the altitude difference in metres.
	function automatic logic [hsd_pkg::HCM_W-1:0] HCM_W_CAST(input logic [16:0] h);
		return hsd_pkg::HCM_W'(h) * hsd_pkg::HCM_W'(100);
	endfunction

	// Input decode: range checks, angle differences and magnitudes.
	logic signed [26:0] ang [4];
	logic [25:0]        mag [4];
	logic [25:0]        mag_s1 [4];
	logic [3:0]         neg_s1;
	logic signed [16:0] dalt;
	logic [16:0]        halt;
	logic signed [QW-1:0] la1, la2, lo1, lo2;
	logic signed [16:0] al1, al2;

	always_comb begin
		la1 = QW'(pair_in.first_latitude);
		la2 = QW'(pair_in.second_latitude);
		lo1 = QW'(pair_in.first_longitude);
		lo2 = QW'(pair_in.second_longitude);
		al1 = 17'(pair_in.first_altitude);
		al2 = 17'(pair_in.second_altitude);
		ang[0] = 27'(pair_in.first_latitude);
		ang[1] = 27'(pair_in.second_latitude);
		ang[2] = 27'(pair_in.second_latitude) - 27'(pair_in.first_latitude);
		ang[3] = 27'(pair_in.second_longitude) - 27'(pair_in.first_longitude);
		for (int k = 0; k < 4; k++) begin
			mag[k] = ang[k][26] ? 26'(-ang[k]) : ang[k][25:0];
		end
		dalt = al2 - al1;
		halt = dalt[16] ? 17'(-dalt) : 17'(dalt);
		sb_in.h_cm = HCM_W_CAST(halt);
		sb_in.ok = (la1 < LAT_LIM) && (la1 > -LAT_LIM) && (la2 < LAT_LIM) &&
			(la2 > -LAT_LIM) && (lo1 < LON_LIM) && (lo1 > -LON_LIM) &&
			(lo2 < LON_LIM) && (lo2 > -LON_LIM) && (al1 < hsd_pkg::ALT_MAX) &&
			(al1 > hsd_pkg::ALT_MIN) && (al2 < hsd_pkg::ALT_MAX) &&
			(al2 > hsd_pkg::ALT_MIN);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				mag_s1[k] <= mag[k];
				neg_s1[k] <= ang[k][26];
			end
		end
	end

	// Degree to radian conversion: partial products, then sum and round.
	logic [42:0] pph_s2 [4];
	logic [43:0] ppl_s2 [4];
	logic [3:0]  neg_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				pph_s2[k] <= 43'(mag_s1[k]) * 43'(D2R_HI);
				ppl_s2[k] <= 44'(mag_s1[k]) * 44'(D2R_LO);
			end
			neg_s2 <= neg_s1;
		end
	end

	logic [61:0]          full [4];
	logic [61:0]          rnd [4];
	logic signed [QW-1:0] rad_s3 [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			full[k] = (62'(pph_s2[k]) << 18) + 62'(ppl_s2[k]);
			rnd[k]  = (k < 2) ? (full[k] + RND0) >> SH0 : (full[k] + RND1) >> SH1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				rad_s3[k] <= neg_s2[k] ? -QW'(rnd[k]) : QW'(rnd[k]);
			end
		end
	end

	// Fold the half longitude difference into the CORDIC range.
	logic signed [QW-1:0] z_s4 [4];

	always_ff @(posedge clk) begin
		if (adv) begin
			z_s4[0] <= rad_s3[0];
			z_s4[1] <= rad_s3[1];
			z_s4[2] <= rad_s3[2];
			if (rad_s3[3] > hsd_pkg::HALF_PI_Q30) begin
				z_s4[3] <= rad_s3[3] - hsd_pkg::PI_Q30;
			end else if (rad_s3[3] < -hsd_pkg::HALF_PI_Q30) begin
				z_s4[3] <= rad_s3[3] + hsd_pkg::PI_Q30;
			end else begin
				z_s4[3] <= rad_s3[3];
			end
		end
	end

	// Four rotation chains: cos lat1, cos lat2, sin dlat/2, sin dlon/2.
	wire signed [QW-1:0] rot_x [4][CS+1];
	wire signed [QW-1:0] rot_y [4][CS+1];
	wire signed [QW-1:0] rot_z [4][CS+1];

	for (genvar c = 0; c < 4; c++) begin : g_rot
		assign rot_x[c][0] = CORDIC_K;
		assign rot_y[c][0] = '0;
		assign rot_z[c][0] = z_s4[c];
		for (genvar j = 0; j < CS; j++) begin : g_cell
			hsd_cordic_cell #(.I(j), .VECTOR(1'b0)) u_cell (
				.clk(clk), .en(adv),
				.x_i(rot_x[c][j]), .y_i(rot_y[c][j]), .z_i(rot_z[c][j]),
				.x_o(rot_x[c][j+1]), .y_o(rot_y[c][j+1]), .z_o(rot_z[c][j+1])
			);
		end
	end

	// Haversine term: products of cosines and squared sines.
	logic [32:0] c1p, c2p, s1m, s2m;
	logic [63:0] pcc_s5, ps1_s5, ps2_s5;

	always_comb begin
		c1p = rot_x[0][CS][QW-1] ? '0 : rot_x[0][CS][32:0];
		c2p = rot_x[1][CS][QW-1] ? '0 : rot_x[1][CS][32:0];
		s1m = rot_y[2][CS][QW-1] ? 33'(-rot_y[2][CS]) : rot_y[2][CS][32:0];
		s2m = rot_y[3][CS][QW-1] ? 33'(-rot_y[3][CS]) : rot_y[3][CS][32:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pcc_s5 <= 64'(c1p * c2p);
			ps1_s5 <= 64'(s1m * s1m);
			ps2_s5 <= 64'(s2m * s2m);
		end
	end

	logic [33:0] cc_s6, sq1_s6, sq2_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			cc_s6  <= 34'((pcc_s5 + (64'd1 << 29)) >> 30);
			sq1_s6 <= 34'((ps1_s5 + (64'd1 << 29)) >> 30);
			sq2_s6 <= 34'((ps2_s5 + (64'd1 << 29)) >> 30);
		end
	end

	logic [63:0] p3_s7;
	logic [33:0] sq1_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			p3_s7  <= 64'(cc_s6 * sq2_s6);
			sq1_s7 <= sq1_s6;
		end
	end

	// Sum and clamp at one.
	logic [34:0] asum;
	logic [30:0] a_s8;

	assign asum = 35'(sq1_s7) + 35'((p3_s7 + (64'd1 << 29)) >> 30);

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s8 <= (asum > 35'(hsd_pkg::ONE_Q30)) ? 31'(hsd_pkg::ONE_Q30) : asum[30:0];
		end
	end

	// Square roots of a and of one minus a.
	wire [hsd_pkg::HV_NW-1:0] hv_n [2][HVC+1];
	wire [hsd_pkg::HV_NW-1:0] hv_r [2][HVC+1];

	assign hv_n[0][0] = hsd_pkg::HV_NW'(a_s8) << 30;
	assign hv_n[1][0] = hsd_pkg::HV_NW'(31'(hsd_pkg::ONE_Q30) - a_s8) << 30;

	for (genvar c = 0; c < 2; c++) begin : g_hv
		assign hv_r[c][0] = '0;
		for (genvar j = 0; j < HVC; j++) begin : g_cell
			hsd_isqrt_cell #(.NW(hsd_pkg::HV_NW), .I(j)) u_cell (
				.clk(clk), .en(adv),
				.n_i(hv_n[c][j]), .r_i(hv_r[c][j]),
				.n_o(hv_n[c][j+1]), .r_o(hv_r[c][j+1])
			);
		end
	end

	// Vectoring chain gives atan2(sqrt(a), sqrt(1-a)).
	wire signed [QW-1:0] vec_x [CS+1];
	wire signed [QW-1:0] vec_y [CS+1];
	wire signed [QW-1:0] vec_z [CS+1];

	assign vec_x[0] = QW'(hv_r[1][HVC][30:0]);
	assign vec_y[0] = QW'(hv_r[0][HVC][30:0]);
	assign vec_z[0] = '0;

	for (genvar j = 0; j < CS; j++) begin : g_vec
		hsd_cordic_cell #(.I(j), .VECTOR(1'b1)) u_cell (
			.clk(clk), .en(adv),
			.x_i(vec_x[j]), .y_i(vec_y[j]), .z_i(vec_z[j]),
			.x_o(vec_x[j+1]), .y_o(vec_y[j+1]), .z_o(vec_z[j+1])
		);
	end

	// Surface distance: radius times the central angle, in two products.
	logic [33:0] cang;
	logic [50:0] p1_s9;
	logic [48:0] p2_s9;

	assign cang = vec_z[CS][QW-1] ? '0 : {vec_z[CS][32:0], 1'b0};

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s9 <= 51'(radius_q) * 51'(cang[33:16]);
			p2_s9 <= 49'(radius_q) * 49'(cang[15:0]);
		end
	end

	// Millimetres plus half a centimetre, ready for the divide by ten.
	logic [51:0] smm_sum;
	logic [37:0] v_s10;

	assign smm_sum = 52'(p1_s9) + 52'(p2_s9 >> 16) + 52'd8192;

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s10 <= 38'(smm_sum >> 14) + 38'd5;
		end
	end

	logic [54:0] qh_s11;
	logic [57:0] ql_s11;

	always_ff @(posedge clk) begin
		if (adv) begin
			qh_s11 <= 55'(v_s10) * 55'(M_HI);
			ql_s11 <= 58'(v_s10) * 58'(M_LO);
		end
	end

	logic [75:0] qsum;
	logic [35:0] scm_s12;

	assign qsum = (76'(qh_s11) << 20) + 76'(ql_s11);

	always_ff @(posedge clk) begin
		if (adv) begin
			scm_s12 <= 36'(qsum >> 40);
		end
	end

	// Squares of the surface and height legs, then their sum.
	logic [63:0] sqs_s13;
	logic [47:0] sqh_s13;
	logic [63:0] n_s14;

	always_ff @(posedge clk) begin
		if (adv) begin
			sqs_s13 <= 64'(scm_s12 * scm_s12);
			sqh_s13 <= 48'(sb_q[IDX_S13-1].h_cm) * 48'(sb_q[IDX_S13-1].h_cm);
			n_s14   <= sqs_s13 + 64'(sqh_s13);
		end
	end

	// Final root chain; the remainder decides the rounding.
	wire [hsd_pkg::FR_NW-1:0] fr_n [FRC+1];
	wire [hsd_pkg::FR_NW-1:0] fr_r [FRC+1];

	assign fr_n[0] = n_s14;
	assign fr_r[0] = '0;

	for (genvar j = 0; j < FRC; j++) begin : g_fr
		hsd_isqrt_cell #(.NW(hsd_pkg::FR_NW), .I(j)) u_cell (
			.clk(clk), .en(adv),
			.n_i(fr_n[j]), .r_i(fr_r[j]),
			.n_o(fr_n[j+1]), .r_o(fr_r[j+1])
		);
	end

	// Round to nearest, saturate, and zero the word for bad coordinates.
	logic [32:0]                  rr;
	logic [hsd_pkg::DIST_W-1:0]   dist_s15;

	assign rr = 33'(fr_r[FRC][31:0]) +
		33'(fr_n[FRC] > hsd_pkg::FR_NW'(fr_r[FRC][31:0]));

	always_ff @(posedge clk) begin
		if (adv) begin
			if (!sb_q[L-2].ok) begin
				dist_s15 <= '0;
			end else if (rr > 33'(hsd_pkg::DIST_MAX)) begin
				dist_s15 <= hsd_pkg::DIST_MAX;
			end else begin
				dist_s15 <= rr[hsd_pkg::DIST_W-1:0];
			end
		end
	end

	assign dist_out.distance_cm  = dist_s15;
	assign dist_out.coords_valid = sb_q[L-1].ok;

endmodule

### rtl/core/hsd_cordic_cell.sv
// One CORDIC micro-rotation with its output register.
// Depends on hsd_pkg for the datapath width and the step angles.
module hsd_cordic_cell #(
	parameter int I      = 0,
	parameter bit VECTOR = 1'b0
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [hsd_pkg::Q_W-1:0]   x_i,
	input  logic signed [hsd_pkg::Q_W-1:0]   y_i,
	input  logic signed [hsd_pkg::Q_W-1:0]   z_i,
	output logic signed [hsd_pkg::Q_W-1:0]   x_o,
	output logic signed [hsd_pkg::Q_W-1:0]   y_o,
	output logic signed [hsd_pkg::Q_W-1:0]   z_o
);

	localparam logic signed [hsd_pkg::Q_W-1:0] ATAN = hsd_pkg::atan_q30(I);

	logic signed [hsd_pkg::Q_W-1:0] dx;
	logic signed [hsd_pkg::Q_W-1:0] dy;
	logic                           up;

	// Rotation steers on the residual angle, vectoring on the sign of y.
	assign dx = y_i >>> I;
	assign dy = x_i >>> I;
	assign up = VECTOR ? y_i[hsd_pkg::Q_W-1] : ~z_i[hsd_pkg::Q_W-1];

	// Step register, advanced with the rest of the pipeline.
	always_ff @(posedge clk) begin
		if (en) begin
			x_o <= up ? x_i - dx : x_i + dx;
			y_o <= up ? y_i + dy : y_i - dy;
			z_o <= up ? z_i - ATAN : z_i + ATAN;
		end
	end

endmodule

### rtl/core/hsd_isqrt_cell.sv
// One bit of a digit-recurrence integer square root with its register.
// Depends on nothing but its parameters.
module hsd_isqrt_cell #(
	parameter int NW = 64,
	parameter int I  = 0
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] n_i,
	input  logic [NW-1:0] r_i,
	output logic [NW-1:0] n_o,
	output logic [NW-1:0] r_o
);

	localparam logic [NW:0] BIT = (NW + 1)'(1) << (NW - 2 - 2 * I);

	logic [NW:0] trial;
	logic        take;

	// Try to subtract the candidate; the remainder keeps what is left.
	assign trial = {1'b0, r_i} + BIT;
	assign take  = {1'b0, n_i} >= trial;

	always_ff @(posedge clk) begin
		if (en) begin
			n_o <= take ? n_i - trial[NW-1:0] : n_i;
			r_o <= take ? (r_i >> 1) + BIT[NW-1:0] : r_i >> 1;
		end
	end

endmodule

### tb/testbench.sv
// Testbench for haversine_slant_distance: drives point pairs with bursts and gaps,
// stalls the result channel, and checks every distance word against a predictor.
// Depends on hsd_pkg, hsd_if and the haversine_slant_distance RTL.
`timescale 1ns / 100ps

module testbench;
	import hsd_pkg::*;

	localparam int LATENCY = 2 * CORDIC_STAGES + 78;
	localparam int IDLE_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 1850;
	localparam longint LAT_LIM = 90 * 65536;
	localparam longint LON_LIM = 180 * 65536;

	typedef struct packed {
		logic signed [LAT_W-1:0] lat1;
		logic signed [LON_W-1:0] lon1;
		logic signed [ALT_W-1:0] alt1;
		logic signed [LAT_W-1:0] lat2;
		logic signed [LON_W-1:0] lon2;
		logic signed [ALT_W-1:0] alt2;
	} pair_t;

	localparam int PAIR_W = $bits(pair_t);

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              ok;
	} dist_word_t;

	// Fixed-point predictor of the slant distance plus the queue of expected words.
	class distance_board;
		longint atan_tab[CORDIC_STAGES];
		longint inv_gain, pi_q30, half_pi_q30;
		longint unsigned d2r_q40;
		logic [RADIUS_W-1:0] radius;
		dist_word_t expected_words[$];
		int errors;

		function new();
			errors = 0;
			radius = RADIUS_RESET;
			build_constants();
		endfunction

		function longint unsigned root_floor(longint unsigned n_in);
			longint unsigned n, r, b;
			n = n_in;
			r = 0;
			b = 64'd1 << 62;
			for (int i = 0; i < 32; i++) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		// Arctangent of 1/n in Q62 by its series.
		function longint unsigned atan_inv(longint unsigned n);
			longint unsigned term, nn, sum, t, k;
			term = (64'd1 << 62) / n;
			nn = n * n;
			sum = 0;
			k = 0;
			while (term != 0) begin
				t = term / (2 * k + 1);
				if (k[0]) sum = sum - t;
				else sum = sum + t;
				term = term / nn;
				k++;
			end
			return sum;
		endfunction

		// Arctangent of 2^-i in Q62.
		function longint unsigned atan_shift(int i);
			longint unsigned sum, t;
			sum = 0;
			for (int k = 0; (2 * k + 1) * i <= 62; k++) begin
				t = (64'd1 << (62 - (2 * k + 1) * i)) / (2 * k + 1);
				if (k % 2) sum = sum - t;
				else sum = sum + t;
			end
			return sum;
		endfunction

		function void rotate(longint x0, longint ang, output longint xo, output longint yo);
			longint x, y, z, dx, dy;
			x = x0;
			y = 0;
			z = ang;
			for (int i = 0; i < CORDIC_STAGES; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= atan_tab[i];
				end else begin
					x += dx; y -= dy; z += atan_tab[i];
				end
			end
			xo = x;
			yo = y;
		endfunction

		function void build_constants();
			longint unsigned pq, v, ax, ay, mag;
			longint x, y;
			pq = 4 * atan_inv(5) - atan_inv(239);
			for (int i = 0; i < CORDIC_STAGES; i++) begin
				v = (i == 0) ? pq : atan_shift(i);
				atan_tab[i] = longint'((v + (64'd1 << 31)) >> 32);
			end
			pi_q30 = longint'((pq + (64'd1 << 29)) >> 30);
			half_pi_q30 = longint'((pq + (64'd1 << 30)) >> 31);
			d2r_q40 = ((pq / 45) + (64'd1 << 21)) >> 22;
			rotate(longint'(ONE_Q30), 0, x, y);
			ax = longint'(x < 0 ? -x : x);
			ay = longint'(y < 0 ? -y : y);
			mag = root_floor(ax * ax + ay * ay);
			if (mag == 0) mag = 1;
			inv_gain = longint'(((64'd1 << 60) + mag / 2) / mag);
		endfunction

		// Fixed-point degrees to Q30 radians, halved when extra is 1.
		function longint radians(longint d, int extra);
			int sh;
			longint unsigned mag;
			longint r;
			sh = ANGLE_FRACTION_BITS + 10 + extra;
			mag = (d < 0) ? -d : d;
			r = longint'((mag * d2r_q40 + (64'd1 << (sh - 1))) >> sh);
			return (d < 0) ? -r : r;
		endfunction

		function longint unsigned square_q30(longint v);
			longint unsigned m;
			m = (v < 0) ? -v : v;
			return (m * m + (64'd1 << 29)) >> 30;
		endfunction

		function dist_word_t slant_distance(pair_t p);
			dist_word_t w;
			longint lat1, lon1, alt1, lat2, lon2, alt2;
			longint c1, c2, s1, s2, junk, th, x, y, z, dx, dy;
			longint unsigned a, cc, ya, xa, c, r, s_mm, s_cm, h_cm, n, rt;
			lat1 = p.lat1; lon1 = p.lon1; alt1 = p.alt1;
			lat2 = p.lat2; lon2 = p.lon2; alt2 = p.alt2;
			w = '0;
			if (!(lat1 < LAT_LIM && lat1 > -LAT_LIM && lat2 < LAT_LIM && lat2 > -LAT_LIM &&
				lon1 < LON_LIM && lon1 > -LON_LIM && lon2 < LON_LIM && lon2 > -LON_LIM &&
				alt1 < 8848 && alt1 > -423 && alt2 < 8848 && alt2 > -423))
				return w;
			rotate(inv_gain, radians(lat1, 0), c1, junk);
			rotate(inv_gain, radians(lat2, 0), c2, junk);
			if (c1 < 0) c1 = 0;
			if (c2 < 0) c2 = 0;
			rotate(inv_gain, radians(lat2 - lat1, 1), junk, s1);
			th = radians(lon2 - lon1, 1);
			if (th > half_pi_q30) th -= pi_q30;
			else if (th < -half_pi_q30) th += pi_q30;
			rotate(inv_gain, th, junk, s2);
			// Haversine term, clamped at one.
			cc = (longint'(c1) * longint'(c2) + (64'd1 << 29)) >> 30;
			a = square_q30(s1) + ((cc * square_q30(s2) + (64'd1 << 29)) >> 30);
			if (a > ONE_Q30) a = ONE_Q30;
			ya = root_floor(a << 30);
			xa = root_floor((ONE_Q30 - a) << 30);
			// Vectoring pass gives the half central angle.
			x = xa; y = ya; z = 0;
			for (int i = 0; i < CORDIC_STAGES; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x += dx; y -= dy; z += atan_tab[i];
				end else begin
					x -= dx; y += dy; z -= atan_tab[i];
				end
			end
			if (z < 0) z = 0;
			c = 2 * z;
			r = radius;
			s_mm = (r * (c >> 16) + ((r * (c & 64'hFFFF)) >> 16) + 8192) >> 14;
			s_cm = (s_mm + 5) / 10;
			h_cm = longint'(alt2 >= alt1 ? alt2 - alt1 : alt1 - alt2) * 100;
			n = s_cm * s_cm + h_cm * h_cm;
			rt = root_floor(n);
			if (n - rt * rt > rt) rt++;
			if (rt > DIST_MAX) rt = DIST_MAX;
			w.distance = rt[DIST_W-1:0];
			w.ok = 1'b1;
			return w;
		endfunction

		function void note_pair(pair_t p);
			expected_words.push_back(slant_distance(p));
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
			errors++;
		endtask

		task check_word(dist_word_t got);
			dist_word_t want;
			if (expected_words.size() == 0) begin
				report("unexpected word", got.distance, -1);
			end else begin
				want = expected_words.pop_front();
				if (got.distance !== want.distance)
					report("distance_cm", got.distance, want.distance);
				if (got.ok !== want.ok) report("coords_valid", got.ok, want.ok);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [RADIUS_W-1:0] cfg_wdata;
	hsd_pair_if pair_in ();
	hsd_dist_if dist_out ();
	distance_board board;
	int idle_cycles;
	int burst_left;
	int stall_left;
	int segment_left;
	int stall_mode;

	haversine_slant_distance dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.pair_in(pair_in.sink),
		.dist_out(dist_out.source)
	);

	// Clock, 4 ns period.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Monitor: note accepted pairs and check accepted result words.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pair_in.valid && pair_in.ready) board.note_pair({pair_in.first_latitude,
				pair_in.first_longitude, pair_in.first_altitude, pair_in.second_latitude,
				pair_in.second_longitude, pair_in.second_altitude});
			if (dist_out.valid && dist_out.ready)
				board.check_word({dist_out.distance_cm, dist_out.coords_valid});
		end
	end

	// Watchdog on cycles with no word moving on either channel.
	always @(posedge clk) begin
		if ((pair_in.valid && pair_in.ready) || (dist_out.valid && dist_out.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver stall pattern: segments that are always ready, lightly or heavily stalled.
	always @(negedge clk) begin
		if (segment_left == 0) begin
			segment_left = $urandom_range(20, 200);
			stall_mode = $urandom_range(0, 2);
		end
		segment_left--;
		if (stall_left > 0) begin
			stall_left--;
			dist_out.ready = 1'b0;
		end else if (stall_mode == 1 && $urandom_range(0, 3) == 0) begin
			stall_left = $urandom_range(0, 3);
			dist_out.ready = 1'b0;
		end else if (stall_mode == 2 && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(5, 30);
			dist_out.ready = 1'b0;
		end else begin
			dist_out.ready = 1'b1;
		end
	end

	// Drive one pair and hold it until accepted; gaps come before most bursts.
	task send_pair(pair_t p);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				pair_in.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		pair_in.valid = 1'b1;
		{pair_in.first_latitude, pair_in.first_longitude, pair_in.first_altitude,
			pair_in.second_latitude, pair_in.second_longitude, pair_in.second_altitude} = p;
		do @(posedge clk); while (!pair_in.ready);
		@(negedge clk);
	endtask

	// Wait until every expected word is back and the pipeline is empty.
	task drain();
		pair_in.valid = 1'b0;
		while (board.expected_words.size() != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	task write_radius(logic [RADIUS_W-1:0] value);
		cfg_wen = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_wen = 1'b0;
		board.radius = value;
	endtask

	function pair_t point(longint la1, longint lo1, longint al1, longint la2, longint lo2,
		longint al2);
		pair_t p;
		p.lat1 = LAT_W'(la1); p.lon1 = LON_W'(lo1); p.alt1 = ALT_W'(al1);
		p.lat2 = LAT_W'(la2); p.lon2 = LON_W'(lo2); p.alt2 = ALT_W'(al2);
		return p;
	endfunction

	// Random pair: mostly in range, some with one field or the whole pair anywhere in its width, some close pairs.
	function pair_t random_pair();
		pair_t p;
		int pick;
		p.lat1 = LAT_W'(int'($urandom_range(0, 11796478)) - 5898239);
		p.lat2 = LAT_W'(int'($urandom_range(0, 11796478)) - 5898239);
		p.lon1 = LON_W'(int'($urandom_range(0, 23592958)) - 11796479);
		p.lon2 = LON_W'(int'($urandom_range(0, 23592958)) - 11796479);
		p.alt1 = ALT_W'(int'($urandom_range(0, 9269)) - 422);
		p.alt2 = ALT_W'(int'($urandom_range(0, 9269)) - 422);
		pick = $urandom_range(0, 19);
		case (pick)
			0: p.lat1 = LAT_W'($urandom);
			1: p.lon2 = LON_W'($urandom);
			2: p.alt1 = ALT_W'($urandom);
			3: p = PAIR_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
			4: begin
				p.lat2 = LAT_W'(int'(p.lat1) + int'($urandom_range(0, 2000)) - 1000);
				p.lon2 = LON_W'(int'(p.lon1) + int'($urandom_range(0, 2000)) - 1000);
			end
			default: ;
		endcase
		return p;
	endfunction

	initial begin
		logic [RADIUS_W-1:0] radii[5];
		board = new();
		idle_cycles = 0;
		burst_left = 0;
		stall_left = 0;
		segment_left = 0;
		stall_mode = 0;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		pair_in.valid = 1'b0;
		{pair_in.first_latitude, pair_in.first_longitude, pair_in.first_altitude,
			pair_in.second_latitude, pair_in.second_longitude, pair_in.second_altitude} = '0;
		dist_out.ready = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed pairs at the reset radius: limits, identical and antipodal points.
		send_pair(point(0, 0, 0, 0, 0, 0));
		send_pair(point(LAT_LIM - 1, 0, 0, -LAT_LIM + 1, 0, 0));
		send_pair(point(LAT_LIM, 0, 0, 0, 0, 0));
		send_pair(point(0, 0, 0, -LAT_LIM, 0, 0));
		send_pair(point(0, LON_LIM - 1, 0, 0, -LON_LIM + 1, 0));
		send_pair(point(0, LON_LIM, 0, 0, 0, 0));
		send_pair(point(0, 0, 0, 0, -LON_LIM, 0));
		send_pair(point(0, 0, 8847, 0, 0, -422));
		send_pair(point(0, 0, 8848, 0, 0, 0));
		send_pair(point(0, 0, 0, 0, 0, -423));
		send_pair(point(0, 0, 32767, 0, 0, -32768));
		send_pair(point(0, 0, 0, 0, 180 * 65536 - 1, 0));
		send_pair(point(0, -90 * 65536, 0, 0, 90 * 65536, 0));
		send_pair(point(1000, 2000, 100, 1000, 2000, 100));
		send_pair(point(1000, 2000, 100, 1000, 2000, 200));
		send_pair(point(LAT_LIM - 1, LON_LIM - 1, 8847, -LAT_LIM + 1, -LON_LIM + 1, -422));
		send_pair(point(-8388608, -16777216, -32768, 8388607, 16777215, 32767));
		send_pair(point(45 * 65536, 10 * 65536, 0, 45 * 65536, 11 * 65536, 0));
		send_pair(point(0, 0, 0, 1, 0, 0));
		send_pair(point(0, 0, 0, 0, 1, 0));

		// Random phases, one per radius; the sender drains before each write.
		radii[0] = 33'd6000000000;
		radii[1] = 33'd7000000000;
		radii[2] = '1;
		radii[3] = '0;
		radii[4] = RADIUS_RESET;
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			write_radius(radii[ph]);
			for (int i = 0; i < RANDOM_ITEMS / 5; i++) send_pair(random_pair());
		end

		drain();
		if (board.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
